// File: rtl/irtcd_pkg.sv
// Shared types and constants for the impact/rotation/tilt crash detector.
// Holds the phase codes, the register indexes and reset values, and the
// sample, threshold and result structs. No dependencies.
package irtcd_pkg;

	// Detector phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_ROT  = 2'd1;
	localparam logic [1:0] PH_TILT = 2'd2;

	// Register indexes on the configuration port
	localparam int unsigned CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_IMPACT_ACCEL  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_RATE      = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_WINDOW    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_MIN      = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REST_LOW      = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REST_HIGH     = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REST_HOLD     = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_TIMEOUT  = 4'd7;

	// Register reset values
	localparam logic [15:0] RST_IMPACT_ACCEL = 16'd4000;
	localparam logic [15:0] RST_ROT_RATE     = 16'd2000;
	localparam logic [15:0] RST_ROT_WINDOW   = 16'd500;
	localparam logic [10:0] RST_TILT_MIN     = 11'd600;
	localparam logic [15:0] RST_REST_LOW     = 16'd700;
	localparam logic [15:0] RST_REST_HIGH    = 16'd1300;
	localparam logic [15:0] RST_REST_HOLD    = 16'd3000;
	localparam logic [15:0] RST_TILT_TIMEOUT = 16'd8000;

	// Thresholds seen by the detector core
	typedef struct packed {
		logic [15:0] impact_accel_mg;
		logic [15:0] rotation_rate_ddps;
		logic [15:0] rotation_window_ms;
		logic [10:0] tilt_min_ddeg;
		logic [15:0] rest_low_mg;
		logic [15:0] rest_high_mg;
		logic [15:0] rest_hold_ms;
		logic [15:0] tilt_timeout_ms;
	} cfg_t;

	// One motion sample
	typedef struct packed {
		logic [31:0] time_ms;
		logic [15:0] accel_mg;
		logic [15:0] rate_ddps;
		logic [10:0] tilt_ddeg;
		logic        new_event;
	} sample_t;

	// One result
	typedef struct packed {
		logic        crash_detected;
		logic [31:0] detect_time_ms;
		logic [31:0] confirm_delay_ms;
		logic [1:0]  phase;
	} result_t;

endpackage

// File: rtl/irtcd_regs.sv
// Configuration register file for the crash detector.
// Depends on irtcd_pkg for the register indexes, reset values and cfg_t.
module irtcd_regs
	import irtcd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// Write decode; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.impact_accel_mg    <= RST_IMPACT_ACCEL;
			cfg_q.rotation_rate_ddps <= RST_ROT_RATE;
			cfg_q.rotation_window_ms <= RST_ROT_WINDOW;
			cfg_q.tilt_min_ddeg      <= RST_TILT_MIN;
			cfg_q.rest_low_mg        <= RST_REST_LOW;
			cfg_q.rest_high_mg       <= RST_REST_HIGH;
			cfg_q.rest_hold_ms       <= RST_REST_HOLD;
			cfg_q.tilt_timeout_ms    <= RST_TILT_TIMEOUT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMPACT_ACCEL: cfg_q.impact_accel_mg    <= cfg_data;
				REG_ROT_RATE:     cfg_q.rotation_rate_ddps <= cfg_data;
				REG_ROT_WINDOW:   cfg_q.rotation_window_ms <= cfg_data;
				REG_TILT_MIN:     cfg_q.tilt_min_ddeg      <= cfg_data[10:0];
				REG_REST_LOW:     cfg_q.rest_low_mg        <= cfg_data;
				REG_REST_HIGH:    cfg_q.rest_high_mg       <= cfg_data;
				REG_REST_HOLD:    cfg_q.rest_hold_ms       <= cfg_data;
				REG_TILT_TIMEOUT: cfg_q.tilt_timeout_ms    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/irtcd_core.sv
// Detector state and next-state logic: one sample per step.
// Depends on irtcd_pkg for phase codes and the cfg_t/sample_t/result_t types.
module irtcd_core
	import irtcd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  sample_t smp,
	input  cfg_t    cfg,
	output result_t res
);

	logic [1:0]  phase_q;
	logic [31:0] impact_time_q;
	logic [31:0] hold_start_q;
	logic        hold_active_q;
	logic        detected_q;
	logic [31:0] detect_time_q;

	logic [1:0]  phase_b, phase_n;
	logic [31:0] impact_b, impact_n;
	logic [31:0] hold_start_b, hold_start_n;
	logic        hold_active_b, hold_active_n;
	logic        detected_b, detected_n;
	logic [31:0] detect_time_b, detect_time_n;
	logic [31:0] since_impact;
	logic [31:0] since_hold;
	logic        at_rest;
	logic        rot_ok;
	logic        rot_late;

	// State as seen by this sample, after a new-event clear
	always_comb begin
		if (smp.new_event) begin
			phase_b       = PH_IDLE;
			impact_b      = '0;
			hold_start_b  = '0;
			hold_active_b = 1'b0;
			detected_b    = 1'b0;
			detect_time_b = '0;
		end else begin
			phase_b       = phase_q;
			impact_b      = impact_time_q;
			hold_start_b  = hold_start_q;
			hold_active_b = hold_active_q;
			detected_b    = detected_q;
			detect_time_b = detect_time_q;
		end
	end

	assign since_impact = smp.time_ms - impact_b;
	assign rot_late     = since_impact > {16'd0, cfg.rotation_window_ms};
	assign rot_ok       = (smp.rate_ddps >= cfg.rotation_rate_ddps) && !rot_late;
	assign at_rest      = (smp.tilt_ddeg >= cfg.tilt_min_ddeg) &&
	                      (smp.accel_mg >= cfg.rest_low_mg) &&
	                      (smp.accel_mg <= cfg.rest_high_mg);
	// Hold interval restarts at this sample when no hold is running
	assign since_hold   = hold_active_b ? (smp.time_ms - hold_start_b) : '0;

	// Phase machine; frozen once a crash is confirmed
	always_comb begin
		phase_n       = phase_b;
		impact_n      = impact_b;
		hold_start_n  = hold_start_b;
		hold_active_n = hold_active_b;
		detected_n    = detected_b;
		detect_time_n = detect_time_b;
		if (!detected_b) begin
			unique case (phase_b)
				PH_ROT: begin
					if (rot_ok) begin
						phase_n = PH_TILT;
					end else if (rot_late) begin
						phase_n = PH_IDLE;
					end
				end
				PH_TILT: begin
					if (at_rest) begin
						hold_active_n = 1'b1;
						if (!hold_active_b) begin
							hold_start_n = smp.time_ms;
						end
						if (since_hold >= {16'd0, cfg.rest_hold_ms}) begin
							detected_n    = 1'b1;
							detect_time_n = smp.time_ms;
						end
					end else begin
						hold_active_n = 1'b0;
					end
					// Timeout loses to a detection on the same sample
					if (!detected_n && since_impact > {16'd0, cfg.tilt_timeout_ms}) begin
						phase_n       = PH_IDLE;
						hold_active_n = 1'b0;
					end
				end
				default: begin
					phase_n = PH_IDLE;
					if (smp.accel_mg >= cfg.impact_accel_mg) begin
						phase_n  = PH_ROT;
						impact_n = smp.time_ms;
					end
				end
			endcase
		end
	end

	// State update on each processed sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			impact_time_q <= '0;
			hold_start_q  <= '0;
			hold_active_q <= 1'b0;
			detected_q    <= 1'b0;
			detect_time_q <= '0;
		end else if (step) begin
			phase_q       <= phase_n;
			impact_time_q <= impact_n;
			hold_start_q  <= hold_start_n;
			hold_active_q <= hold_active_n;
			detected_q    <= detected_n;
			detect_time_q <= detect_time_n;
		end
	end

	// Result after the update
	assign res.crash_detected   = detected_n;
	assign res.detect_time_ms   = detected_n ? detect_time_n : '0;
	assign res.confirm_delay_ms = detected_n ? (detect_time_n - impact_n) : '0;
	assign res.phase            = phase_n;

endmodule

// File: rtl/impact_rotation_tilt_crash_detector.sv
// Impact/rotation/tilt crash detector, top level.
// Path from input request to result: input register, then result register.
// Takes one request per cycle while in_stall is low; the state update is a single compare/subtract pass.
// in_stall follows out_stall only while both registers are full.
// Reset (arst_n low, asynchronous): pipeline empty, phase idle, thresholds at defaults.
// Depends on irtcd_pkg, irtcd_regs and irtcd_core.
module impact_rotation_tilt_crash_detector
	import irtcd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [31:0]          time_ms,
	input  logic [15:0]          accel_mg,
	input  logic [15:0]          rate_ddps,
	input  logic [10:0]          tilt_ddeg,
	input  logic                 new_event,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 crash_detected,
	output logic [31:0]          detect_time_ms,
	output logic [31:0]          confirm_delay_ms,
	output logic [1:0]           phase,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	cfg_t    cfg;
	sample_t smp_s1;
	logic    valid_s1;
	result_t res_c;
	result_t res_s2;
	logic    valid_s2;
	logic    out_free;
	logic    step;
	logic    in_take;

	irtcd_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Handshake: input stage moves on when the result register frees up
	assign out_free = !valid_s2 || !out_stall;
	assign step     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || out_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			smp_s1 <= '{time_ms: time_ms, accel_mg: accel_mg, rate_ddps: rate_ddps,
			            tilt_ddeg: tilt_ddeg, new_event: new_event};
		end
	end

	irtcd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.smp    (smp_s1),
		.cfg    (cfg),
		.res    (res_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res_c;
		end
	end

	assign out_valid        = valid_s2;
	assign crash_detected   = res_s2.crash_detected;
	assign detect_time_ms   = res_s2.detect_time_ms;
	assign confirm_delay_ms = res_s2.confirm_delay_ms;
	assign phase            = res_s2.phase;

endmodule

// File: rtl/irtcd_checker.sv
// Port-level checks for the crash detector, bound to the top level.
// Depends on irtcd_pkg for the phase codes.
module irtcd_checker
	import irtcd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        crash_detected,
	input logic [31:0] detect_time_ms,
	input logic [31:0] confirm_delay_ms,
	input logic [1:0]  phase
);

	// A confirmed crash is only reported from the tilt phase
	a_detect_in_tilt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && crash_detected |-> phase == PH_TILT)
		else $error("crash reported outside tilt phase");

	// Times read zero until a crash is confirmed
	a_zero_before_detect: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !crash_detected |-> detect_time_ms == 32'd0 && confirm_delay_ms == 32'd0)
		else $error("nonzero times without detection");

	// The unused phase code never shows
	a_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> phase != 2'd3)
		else $error("unused phase code on output");

	// A stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(crash_detected) &&
		$stable(detect_time_ms) && $stable(confirm_delay_ms) && $stable(phase))
		else $error("stalled result changed");

endmodule

bind impact_rotation_tilt_crash_detector irtcd_checker u_irtcd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.crash_detected   (crash_detected),
	.detect_time_ms   (detect_time_ms),
	.confirm_delay_ms (confirm_delay_ms),
	.phase            (phase)
);
